// File: rtl/rtprp_pkg.sv
// Shared types and constants for the L24 to L16 RTP repacketizer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rtprp_pkg;

    // Incoming packet layout.
    localparam int HEADER_BYTES  = 12;
    localparam int PAYLOAD_BYTES = 6 * 48;
    localparam int TOTAL_BYTES   = HEADER_BYTES + PAYLOAD_BYTES;

    // Width of the byte position counter, which saturates at TOTAL_BYTES.
    localparam int POS_W = $clog2(TOTAL_BYTES + 1);

    // Packet position of the last kept payload byte of an incoming packet.
    localparam int LAST_KEPT_Q   = ((PAYLOAD_BYTES % 3) == 0) ? (PAYLOAD_BYTES - 2)
                                                              : (PAYLOAD_BYTES - 1);
    localparam int LAST_KEPT_POS = HEADER_BYTES + LAST_KEPT_Q;

    // Header byte positions that carry the sequence number, high byte first.
    localparam int SEQ_HI_POS = 2;
    localparam int SEQ_LO_POS = 3;

    // Aggregation register.
    localparam int          BLK_W         = 3;
    localparam logic [2:0]  BLOCKS_RESET  = 3'd5;

    // Result queue depth between the classifier and the output side.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One outgoing byte with its end-of-packet flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/rtprp_front.sv
// Front end of the repacketizer: tracks byte position, block index and
// sequence number, and decides which bytes go out. Depends on rtprp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtprp_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [rtprp_pkg::BLK_W-1:0]  i_cfg_wr_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [7:0]                   i_data,
    input  wire logic                         i_start,
    output logic                              o_push,
    output rtprp_pkg::t_entry                 o_entry,
    input  wire logic                         i_full
);
    import rtprp_pkg::*;

    logic [BLK_W-1:0] r_blocks;
    logic [POS_W-1:0] r_pos;
    logic [1:0]       r_phase;
    logic [BLK_W-1:0] r_block_idx;
    logic [15:0]      r_seq;

    logic [POS_W-1:0] pos;
    logic             accept;
    logic             in_range;
    logic             is_header;
    logic [BLK_W-1:0] eff_blocks;
    logic             last_block;
    logic             emit;
    logic             first_block;

    // A request is taken whenever the queue has room.
    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // A packet start flag puts the position back to zero before the byte is handled.
    assign pos         = i_start ? '0 : r_pos;
    assign in_range    = pos < POS_W'(TOTAL_BYTES);
    assign is_header   = pos < POS_W'(HEADER_BYTES);
    assign first_block = (r_block_idx == '0);

    // A zero interval behaves as one block per outgoing packet.
    assign eff_blocks = (r_blocks == '0) ? BLK_W'(1) : r_blocks;
    assign last_block = ({1'b0, r_block_idx} + (BLK_W + 1)'(1)) >= {1'b0, eff_blocks};

    // Header bytes go out for the first block only; payload drops every third byte.
    assign emit = in_range && (is_header ? first_block : (r_phase != 2'd2));

    always_comb begin
        o_entry.data = i_data;
        if (pos == POS_W'(SEQ_HI_POS)) begin
            o_entry.data = r_seq[15:8];
        end else if (pos == POS_W'(SEQ_LO_POS)) begin
            o_entry.data = r_seq[7:0];
        end
        o_entry.last = !is_header && last_block && (pos == POS_W'(LAST_KEPT_POS));
    end

    assign o_push = accept && emit;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks <= BLOCKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_blocks <= i_cfg_wr_data;
        end
    end

    // Position, sample phase, block index and sequence number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= '0;
            r_block_idx <= '0;
            r_seq       <= '0;
        end else if (accept) begin
            if (in_range) begin
                r_pos <= pos + POS_W'(1);
                if (is_header || r_phase == 2'd2) begin
                    r_phase <= '0;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
                if (first_block && pos == POS_W'(SEQ_LO_POS)) begin
                    r_seq <= r_seq + 16'd1;
                end
                if (pos == POS_W'(TOTAL_BYTES - 1)) begin
                    r_block_idx <= last_block ? '0 : (r_block_idx + BLK_W'(1));
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/rtprp_queue.sv
// Short result queue that decouples the classifier from the output stream.
// Depends on rtprp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rtprp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire rtprp_pkg::t_entry  i_entry,
    output logic                    o_full,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rtprp_pkg::t_entry       o_entry
);
    import rtprp_pkg::*;

    t_entry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/rtp_l24_to_l16_repacketizer.sv
// L24 to L16 RTP repacketizer, top level.
//
// Input stream: one byte of an incoming 300-byte RTP packet per request
// (12 header bytes, 288 bytes of 24-bit samples). s_axis_tuser flags the
// first byte of a packet and resynchronizes the byte position.
// Output stream: bytes of the outgoing L16 packet; m_axis_tlast marks its
// final byte. blocks_per_packet incoming packets make one outgoing packet.
// Configuration: i_cfg_wr_en writes blocks_per_packet (reset 5); write it
// only while the block is idle.
// A kept byte is registered in the queue and shows on the output once the
// entries ahead of it have left. Throughput: one byte per cycle, set by the
// position counters in the front end. A four-entry queue sits between front
// end and output, so the input keeps flowing while the receiver stalls until
// the queue fills; then s_axis_tready drops. Reset empties the queue and
// clears the position, block index and sequence number.
// Depends on rtprp_pkg, rtprp_front and rtprp_queue.
`timescale 1ns / 1ps
`default_nettype none

module rtp_l24_to_l16_repacketizer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [rtprp_pkg::BLK_W-1:0]  i_cfg_wr_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  wire logic                         s_axis_tuser,   // [0] packet_start
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] out_byte
    output logic                              m_axis_tlast
);
    import rtprp_pkg::*;

    logic   push;
    logic   full;
    t_entry front_entry;
    t_entry back_entry;

    // Classifying front end.
    rtprp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_start       (s_axis_tuser),
        .o_push        (push),
        .o_entry       (front_entry),
        .i_full        (full)
    );

    // Result queue feeding the output stream.
    rtprp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .o_full   (full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_entry  (back_entry)
    );

    assign m_axis_tdata = back_entry.data;
    assign m_axis_tlast = back_entry.last;

endmodule

`default_nettype wire
